[rtl/core/tocdv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tocdv_pkg
// Shared types, codes and helpers of the three-oscillator decay voice.
// ----------------------------------------------------------------------------
package tocdv_pkg;

  localparam int NUM_OSC_DEF    = 3;
  localparam int PHASE_BITS_DEF = 32;
  localparam int NUM_STEPS      = 3;
  localparam int STEP_W         = 31;
  localparam int NOTE_W         = 16;
  localparam int SAMPLE_W       = 16;
  localparam int WAVE_W         = 2;
  localparam int DIV_W          = 33;
  localparam int DIVISOR_W      = 16;

  localparam logic [NOTE_W-1:0] NOTE_LENGTH_RESET = 16'd22050;

  localparam logic [WAVE_W-1:0] WAVE_SAW      = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd2;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] REG_WAVE_A      = 2'd0;
  localparam logic [1:0] REG_WAVE_B      = 2'd1;
  localparam logic [1:0] REG_WAVE_C      = 2'd2;
  localparam logic [1:0] REG_NOTE_LENGTH = 2'd3;

  typedef struct packed {
    logic                              start;
    logic [NUM_STEPS-1:0][STEP_W-1:0]  step;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_out_t;

  function automatic logic signed [32:0] osc_wave(input logic [WAVE_W-1:0] kind,
                                                  input logic signed [31:0] p);
    logic signed [33:0] p34;
    logic signed [33:0] half;
    logic signed [33:0] t;
    p34  = 34'(p);
    half = 34'sd1073741824;
    unique case (kind)
      WAVE_SAW:    t = p34;
      WAVE_SQUARE: t = (p34 > 34'sd0) ? 34'sd2147483648 : -34'sd2147483648;
      WAVE_TRIANGLE: begin
        if (p34 > half) begin
          t = (half - p34) <<< 1;
        end else if (p34 < -half) begin
          t = (-half - p34) <<< 1;
        end else begin
          t = p34 <<< 1;
        end
      end
      default: t = 34'sd0;
    endcase
    return 33'(t);
  endfunction

endpackage
`default_nettype wire

[rtl/core/tocdv_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tocdv_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tocdv_divider (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [tocdv_pkg::DIV_W-1:0]        dividend,
  input  wire logic [tocdv_pkg::DIVISOR_W-1:0]    divisor,
  output logic                                    done,
  output logic [tocdv_pkg::DIV_W-1:0]             quotient
);

  localparam int CNT_W = $clog2(tocdv_pkg::DIV_W + 1);

  logic                              busy;
  logic [CNT_W-1:0]                  count;
  logic [tocdv_pkg::DIVISOR_W-1:0]   rem;
  logic [tocdv_pkg::DIVISOR_W-1:0]   dsr;
  logic [tocdv_pkg::DIVISOR_W:0]     shifted;
  logic                              ge;

  assign shifted = {rem, quotient[tocdv_pkg::DIV_W-1]};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(tocdv_pkg::DIV_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[tocdv_pkg::DIV_W-2:0], ge};
      rem      <= ge ? tocdv_pkg::DIVISOR_W'(shifted - {1'b0, dsr})
                     : tocdv_pkg::DIVISOR_W'(shifted);
    end
  end

endmodule
`default_nettype wire

[rtl/core/tocdv_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tocdv_front
// Input acceptance, operation decode and a two-entry command queue.
// ----------------------------------------------------------------------------
module tocdv_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          operation,
  input  wire logic [tocdv_pkg::STEP_W-1:0]  step_a,
  input  wire logic [tocdv_pkg::STEP_W-1:0]  step_b,
  input  wire logic [tocdv_pkg::STEP_W-1:0]  step_c,
  input  wire logic                          pop,
  output tocdv_pkg::queue_out_t              q_out
);

  tocdv_pkg::cmd_t     entry [2];
  tocdv_pkg::cmd_t     cmd_in;
  logic [1:0]          count;
  logic                wr_ptr;
  logic                rd_ptr;
  logic                push;
  logic                take;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign take     = pop && (count != 2'd0);

  assign cmd_in.start   = (operation == tocdv_pkg::OP_START);
  assign cmd_in.step[0] = step_a;
  assign cmd_in.step[1] = step_b;
  assign cmd_in.step[2] = step_c;

  assign q_out.valid = (count != 2'd0);
  assign q_out.cmd   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

[rtl/core/tocdv_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tocdv_back
// Voice engine: envelope, oscillator mix, conversion and output register.
// ----------------------------------------------------------------------------
module tocdv_back #(
  parameter int NUM_OSC    = tocdv_pkg::NUM_OSC_DEF,
  parameter int PHASE_BITS = tocdv_pkg::PHASE_BITS_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire tocdv_pkg::queue_out_t                         q_out,
  output logic                                               pop,
  input  wire logic [NUM_OSC-1:0][tocdv_pkg::WAVE_W-1:0]     wave,
  input  wire logic [tocdv_pkg::NOTE_W-1:0]                  note_length,
  output logic                                               out_valid,
  input  wire logic                                          out_stall,
  output logic signed [tocdv_pkg::SAMPLE_W-1:0]              sample,
  output logic                                               note_end
);

  localparam int IDX_W = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
  localparam int ACC_W = 34;
  localparam logic [PHASE_BITS-1:0] PH_MINUS_ONE = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] POS_FULL = 34'sd2147483648;
  localparam logic signed [ACC_W-1:0] NEG_FULL = -34'sd2147483648;
  localparam int REC_SH = 32 + $clog2(NUM_OSC);
  localparam logic [32:0] REC_M =
    33'(((66'd1 << REC_SH) + 66'(NUM_OSC - 1)) / 66'(NUM_OSC));
  localparam logic [32:0] V_FULL = 33'((66'd1 << 32) / 66'(NUM_OSC));

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV1  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_RECIP = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_WAVE  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_SAT   = 4'd8;
  localparam logic [3:0] S_CONV  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]                                  state;
  logic [NUM_OSC-1:0][PHASE_BITS-1:0]          phase;
  logic [NUM_OSC-1:0][PHASE_BITS-1:0]          phase_step;
  logic [NUM_OSC-1:0][PHASE_BITS-1:0]          step_aligned;
  logic [NUM_OSC-1:0][31:0]                    top;
  logic [tocdv_pkg::NOTE_W-1:0]                remaining;
  logic [IDX_W-1:0]                            idx;
  logic [16:0]                                 r;
  logic [32:0]                                 rr;
  logic [32:0]                                 v;
  logic signed [32:0]                          w;
  logic [31:0]                                 mag;
  logic [64:0]                                 prod;
  logic                                        neg;
  logic signed [ACC_W-1:0]                     acc;
  logic signed [ACC_W-1:0]                     term;
  logic signed [32:0]                          s_sat;
  logic [46:0]                                 pos_prod;
  logic [32:0]                                 neg_mag;
  logic [16:0]                                 neg_val;
  logic [tocdv_pkg::SAMPLE_W-1:0]              smp;
  logic                                        div_start;
  logic [tocdv_pkg::DIV_W-1:0]                 div_dividend;
  logic [tocdv_pkg::DIVISOR_W-1:0]             div_divisor;
  logic                                        div_done;
  logic [tocdv_pkg::DIV_W-1:0]                 div_quot;
  logic                                        full_ratio;
  logic                                        commit;

  for (genvar i = 0; i < NUM_OSC; i++) begin : g_osc
    logic [tocdv_pkg::STEP_W-1:0] raw;
    if (i < tocdv_pkg::NUM_STEPS) begin : g_field
      assign raw = q_out.cmd.step[i];
    end else begin : g_zero
      assign raw = '0;
    end
    if (PHASE_BITS >= 32) begin : g_wide
      assign step_aligned[i] = PHASE_BITS'(raw) << (PHASE_BITS - 32);
      assign top[i]          = phase[i][PHASE_BITS-1 -: 32];
    end else begin : g_narrow
      assign step_aligned[i] = PHASE_BITS'(raw >> (32 - PHASE_BITS));
      assign top[i]          = 32'(phase[i]) << (32 - PHASE_BITS);
    end
  end

  assign pop        = (state == S_IDLE) && q_out.valid;
  assign full_ratio = (note_length == '0) || (remaining >= note_length);
  assign commit     = (state == S_OUT) && (!out_valid || !out_stall);

  assign div_start    = pop && !q_out.cmd.start && (remaining != '0) && !full_ratio;
  assign div_dividend = {1'b0, remaining, 16'h0000};
  assign div_divisor  = note_length;

  assign mag      = w[32] ? 32'(-w) : 32'(w);
  assign term     = ACC_W'(prod[64:32]);
  assign pos_prod = 47'(s_sat[31:0]) * 47'd32767;
  assign neg_mag  = 33'(-s_sat);
  assign neg_val  = 17'(-{1'b0, neg_mag[32:16]});

  tocdv_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      remaining  <= '0;
      out_valid  <= 1'b0;
      idx        <= '0;
      for (int i = 0; i < NUM_OSC; i++) begin
        phase[i]      <= PH_MINUS_ONE;
        phase_step[i] <= '0;
      end
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (q_out.cmd.start) begin
              remaining <= note_length;
              for (int i = 0; i < NUM_OSC; i++) begin
                phase[i]      <= PH_MINUS_ONE;
                phase_step[i] <= step_aligned[i];
              end
            end else if (remaining == '0) begin
              state <= S_OUT;
            end else if (full_ratio) begin
              state <= S_SQ;
            end else begin
              state <= S_DIV1;
            end
          end
        end
        S_DIV1:  if (div_done) state <= S_SQ;
        S_SQ:    state <= S_RECIP;
        S_RECIP: state <= S_SCALE;
        S_SCALE: begin
          idx   <= '0;
          state <= S_WAVE;
        end
        S_WAVE:  state <= S_MUL;
        S_MUL:   state <= S_ACC;
        S_ACC: begin
          if (idx == IDX_W'(NUM_OSC - 1)) begin
            state <= S_SAT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_WAVE;
          end
        end
        S_SAT:   state <= S_CONV;
        S_CONV:  state <= S_OUT;
        S_OUT: begin
          if (commit) begin
            if (remaining != '0) begin
              remaining <= remaining - 1'b1;
            end
            for (int i = 0; i < NUM_OSC; i++) begin
              phase[i] <= phase[i] + phase_step[i];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      r   <= 17'h10000;
      acc <= '0;
      smp <= '0;
    end
    if (state == S_DIV1 && div_done) begin
      r <= div_quot[16:0];
    end
    if (state == S_SQ) begin
      rr <= 33'(34'(r) * 34'(r));
    end
    if (state == S_RECIP) begin
      prod <= 65'(64'(rr[31:0]) * 64'(REC_M[31:0]))
              + (REC_M[32] ? {1'b0, rr[31:0], 32'h0} : 65'h0);
    end
    if (state == S_SCALE) begin
      v <= rr[32] ? V_FULL : 33'(prod >> REC_SH);
    end
    if (state == S_WAVE) begin
      w <= tocdv_pkg::osc_wave(wave[idx], top[idx]);
    end
    if (state == S_MUL) begin
      prod <= 65'(64'(mag) * 64'(v[31:0])) + (v[32] ? {1'b0, mag, 32'h0} : 65'h0);
      neg  <= w[32];
    end
    if (state == S_ACC) begin
      acc <= neg ? acc - term : acc + term;
    end
    if (state == S_SAT) begin
      if (acc > POS_FULL) begin
        s_sat <= 33'(POS_FULL);
      end else if (acc < NEG_FULL) begin
        s_sat <= 33'(NEG_FULL);
      end else begin
        s_sat <= 33'(acc);
      end
    end
    if (state == S_CONV) begin
      smp <= (s_sat > 33'sd0) ? pos_prod[46:31] : neg_val[15:0];
    end
    if (commit) begin
      sample   <= smp;
      note_end <= (remaining <= tocdv_pkg::NOTE_W'(1));
    end
  end

endmodule
`default_nettype wire

[rtl/core/three_osc_decay_voice_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_osc_decay_voice_unit
// Synth voice of phase-accumulator oscillators under a quadratic decay.
//
// Input channel (in_valid/in_stall): operation 0 starts a note and loads the
// phase steps, operation 1 asks for the next sample. Output channel
// (out_valid/out_stall) returns one sample and note_end per sample item,
// nothing for a start item. Waveforms and note length sit on the APB port.
// A two-entry queue takes items while the engine works; the engine does one
// item at a time. A sample item inside a note spends most of its time in the
// 33-step bit-serial divider for the envelope ratio; at full level (count at
// or above the note length) it skips the divider; after the note ends it goes
// straight to the output state. Inside a note it passes the divide, square,
// reciprocal and scale states, then wave, multiply and accumulate for each
// oscillator, then saturate, convert and output before out_valid rises. While
// out_stall is high the finished sample holds in the output register, the
// engine waits on the next result and the queue fills, then in_stall rises.
// Reset empties the queue, sets every phase to -1, clears steps and the note
// count (silent samples, note_end set) and loads the register reset values.
// ----------------------------------------------------------------------------
module three_osc_decay_voice_unit #(
  parameter int NUM_OSC    = tocdv_pkg::NUM_OSC_DEF,
  parameter int PHASE_BITS = tocdv_pkg::PHASE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [3:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                operation,
  input  wire logic [tocdv_pkg::STEP_W-1:0]        step_a,
  input  wire logic [tocdv_pkg::STEP_W-1:0]        step_b,
  input  wire logic [tocdv_pkg::STEP_W-1:0]        step_c,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [tocdv_pkg::SAMPLE_W-1:0]    sample,
  output logic                                     note_end
);

  logic [NUM_OSC-1:0][tocdv_pkg::WAVE_W-1:0]  wave;
  logic [2:0][tocdv_pkg::WAVE_W-1:0]          wave_cfg;
  logic [tocdv_pkg::NOTE_W-1:0]               note_length;
  logic [1:0]                                 reg_idx;
  logic                                       wr_en;
  logic                                       pop;
  tocdv_pkg::queue_out_t                      q_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_cfg    <= {3{tocdv_pkg::WAVE_SAW}};
      note_length <= tocdv_pkg::NOTE_LENGTH_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        tocdv_pkg::REG_WAVE_A:      wave_cfg[0] <= pwdata[tocdv_pkg::WAVE_W-1:0];
        tocdv_pkg::REG_WAVE_B:      wave_cfg[1] <= pwdata[tocdv_pkg::WAVE_W-1:0];
        tocdv_pkg::REG_WAVE_C:      wave_cfg[2] <= pwdata[tocdv_pkg::WAVE_W-1:0];
        tocdv_pkg::REG_NOTE_LENGTH: note_length <= pwdata[tocdv_pkg::NOTE_W-1:0];
      endcase
    end
  end

  for (genvar i = 0; i < NUM_OSC; i++) begin : g_wave
    if (i < 3) begin : g_reg
      assign wave[i] = wave_cfg[i];
    end else begin : g_fixed
      assign wave[i] = tocdv_pkg::WAVE_SAW;
    end
  end

  always_comb begin
    unique case (reg_idx)
      tocdv_pkg::REG_WAVE_A:      prdata = 32'(wave_cfg[0]);
      tocdv_pkg::REG_WAVE_B:      prdata = 32'(wave_cfg[1]);
      tocdv_pkg::REG_WAVE_C:      prdata = 32'(wave_cfg[2]);
      tocdv_pkg::REG_NOTE_LENGTH: prdata = 32'(note_length);
      default:                    prdata = '0;
    endcase
  end

  tocdv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .step_a    (step_a),
    .step_b    (step_b),
    .step_c    (step_c),
    .pop       (pop),
    .q_out     (q_out)
  );

  tocdv_back #(
    .NUM_OSC    (NUM_OSC),
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_out       (q_out),
    .pop         (pop),
    .wave        (wave),
    .note_length (note_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .note_end    (note_end)
  );

endmodule
`default_nettype wire

[tb/three_osc_decay_voice_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_osc_decay_voice_unit_tb
// Feeds start and sample items in random bursts against a stalling receiver,
// runs a bit-exact shadow of the voice (phases, envelope, mix, rounding) and
// compares every sample and note_end flag. Waveforms and note length change
// between phases over the APB port, lengths zero, one and 65535 included.
// ----------------------------------------------------------------------------
module three_osc_decay_voice_unit_tb;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 195;
  localparam int HOLD_CYCLES   = 3000;
  localparam int HOLD_AT       = 400;
  localparam int NOTE_CAP      = 80;
  localparam int NOSC          = tocdv_pkg::NUM_OSC_DEF;
  localparam int STEP_W        = tocdv_pkg::STEP_W;
  localparam int WAVE_W        = tocdv_pkg::WAVE_W;
  localparam int NOTE_W        = tocdv_pkg::NOTE_W;
  localparam int SAMPLE_W      = tocdv_pkg::SAMPLE_W;

  localparam logic [WAVE_W-1:0] WAVE_SILENT = 2'd3;
  localparam logic [STEP_W-1:0] STEP_MAX    = '1;
  localparam longint ONE_Q31  = 64'sd2147483648;
  localparam longint HALF_Q31 = 64'sd1073741824;

  typedef struct packed {
    logic              op;
    logic [STEP_W-1:0] sa;
    logic [STEP_W-1:0] sb;
    logic [STEP_W-1:0] sc;
  } voice_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       ne;
  } voice_sample_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [3:0]                 paddr     = '0;
  logic [31:0]                pwdata    = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic                       operation = 1'b0;
  logic [STEP_W-1:0]          step_a    = '0;
  logic [STEP_W-1:0]          step_b    = '0;
  logic [STEP_W-1:0]          step_c    = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       note_end;

  voice_item_t   pending_items[$];
  voice_sample_t expected_samples[$];
  voice_item_t   cur_item;
  bit            took_item   = 1'b0;
  int            items_taken = 0;
  int            errors      = 0;
  int            burst_left  = 0;
  int            gap_left    = 0;
  int            hold_left   = 0;
  bit            held        = 1'b0;
  int            stall_mode  = 0;
  int            mode_left   = 0;
  int            cyc         = 0;

  logic [31:0]       shadow_phase[NOSC];
  logic [31:0]       shadow_step[NOSC];
  logic [WAVE_W-1:0] shadow_wave[NOSC];
  logic [NOTE_W-1:0] shadow_left;
  logic [NOTE_W-1:0] shadow_len;

  three_osc_decay_voice_unit dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .step_a    (step_a),
    .step_b    (step_b),
    .step_c    (step_c),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .note_end  (note_end)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic void predict_voice(input voice_item_t it);
    longint unsigned r, v, mag;
    longint          p, w, q, mix, level;
    voice_sample_t   res;
    if (it.op == tocdv_pkg::OP_START) begin
      shadow_step[0] = {1'b0, it.sa};
      shadow_step[1] = {1'b0, it.sb};
      shadow_step[2] = {1'b0, it.sc};
      foreach (shadow_phase[i]) shadow_phase[i] = 32'h8000_0000;
      shadow_left = shadow_len;
      return;
    end
    mix    = 0;
    level  = 0;
    res.ne = 1'b1;
    if (shadow_left != 0) begin
      if (shadow_len == 0 || shadow_left >= shadow_len) begin
        r = 64'd65536;
      end else begin
        r = shadow_left;
        r = (r << 16) / shadow_len;
      end
      v = (r * r) / NOSC;
      for (int i = 0; i < NOSC; i++) begin
        p = longint'($signed(shadow_phase[i]));
        case (shadow_wave[i])
          tocdv_pkg::WAVE_SAW:    w = p;
          tocdv_pkg::WAVE_SQUARE: w = (p > 0) ? ONE_Q31 : -ONE_Q31;
          tocdv_pkg::WAVE_TRIANGLE: begin
            if (p > HALF_Q31) w = 2 * (HALF_Q31 - p);
            else if (p < -HALF_Q31) w = 2 * (-HALF_Q31 - p);
            else w = 2 * p;
          end
          default:     w = 0;
        endcase
        mag = (w < 0) ? -w : w;
        q   = (mag * v) >> 32;
        mix += (w < 0) ? -q : q;
      end
      if (mix > ONE_Q31) mix = ONE_Q31;
      if (mix < -ONE_Q31) mix = -ONE_Q31;
      if (mix > 0) level = (mix * 32767) >>> 31;
      else level = -((-mix) >>> 16);
      res.ne = (shadow_left == 1);
      shadow_left--;
    end
    res.smp = level[SAMPLE_W-1:0];
    foreach (shadow_phase[i]) shadow_phase[i] = shadow_phase[i] + shadow_step[i];
    expected_samples.push_back(res);
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return STEP_MAX;
      2:       return STEP_W'($urandom_range(0, 32'h00FF_FFFF));
      default: return STEP_W'($urandom);
    endcase
  endfunction

  function automatic void queue_start(input logic [STEP_W-1:0] a, input logic [STEP_W-1:0] b,
                                      input logic [STEP_W-1:0] c);
    voice_item_t it;
    it.op = tocdv_pkg::OP_START;
    it.sa = a;
    it.sb = b;
    it.sc = c;
    pending_items.push_back(it);
  endfunction

  function automatic void queue_samples(input int n);
    voice_item_t it;
    for (int i = 0; i < n; i++) begin
      it.op = tocdv_pkg::OP_SAMPLE;
      it.sa = STEP_W'($urandom);
      it.sb = STEP_W'($urandom);
      it.sc = STEP_W'($urandom);
      pending_items.push_back(it);
    end
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      tocdv_pkg::REG_WAVE_A:      shadow_wave[0] = val[WAVE_W-1:0];
      tocdv_pkg::REG_WAVE_B:      shadow_wave[1] = val[WAVE_W-1:0];
      tocdv_pkg::REG_WAVE_C:      shadow_wave[2] = val[WAVE_W-1:0];
      tocdv_pkg::REG_NOTE_LENGTH: shadow_len = val[NOTE_W-1:0];
      default:                    ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0);
    // let a trailing start item drain out of the engine
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    voice_sample_t want;
    took_item = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        took_item = 1'b1;
        items_taken++;
        predict_voice(cur_item);
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("sample: none expected, got %0d note_end %0b", sample, note_end);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (sample !== want.smp) begin
            $error("sample: expected %0d, actual %0d", want.smp, sample);
            errors++;
          end
          if (note_end !== want.ne) begin
            $error("note_end: expected %0b, actual %0b", want.ne, note_end);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    logic next_valid;
    next_valid = in_valid && !took_item;
    if (!rst && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        cur_item   = pending_items.pop_front();
        operation <= cur_item.op;
        step_a    <= cur_item.sa;
        step_b    <= cur_item.sb;
        step_c    <= cur_item.sc;
        next_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
    in_valid <= next_valid;
  end

  always @(negedge clk) begin
    logic st;
    st = 1'b0;
    cyc++;
    if (!rst) begin
      // hold the output once long enough to back up the input
      if (!held && items_taken >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        st = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 300);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       st = 1'b0;
          1:       st = ($urandom_range(0, 3) == 0);
          2:       st = ($urandom_range(0, 3) != 0);
          default: st = ((cyc % 7) < 3);
        endcase
      end
    end
    out_stall <= st;
  end

  initial begin
    int          budget;
    int          n;
    logic [15:0] len;
    voice_item_t it;
    foreach (shadow_phase[i]) begin
      shadow_phase[i] = 32'h8000_0000;
      shadow_step[i]  = '0;
      shadow_wave[i]  = tocdv_pkg::WAVE_SAW;
    end
    shadow_left = '0;
    shadow_len  = tocdv_pkg::NOTE_LENGTH_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // silent voice straight out of reset
    queue_samples(2);
    settle();

    reg_write(tocdv_pkg::REG_WAVE_A, 32'(tocdv_pkg::WAVE_SAW));
    reg_write(tocdv_pkg::REG_WAVE_B, 32'(tocdv_pkg::WAVE_SQUARE));
    reg_write(tocdv_pkg::REG_WAVE_C, 32'(tocdv_pkg::WAVE_TRIANGLE));
    reg_write(tocdv_pkg::REG_NOTE_LENGTH, 32'd4);
    queue_start(STEP_MAX, '0, 31'h4000_0000);
    queue_samples(5);
    queue_start('0, STEP_MAX, 31'd1);
    queue_samples(2);
    settle();

    // unused waveform code and an empty note
    reg_write(tocdv_pkg::REG_WAVE_A, 32'(WAVE_SILENT));
    reg_write(tocdv_pkg::REG_WAVE_B, 32'(tocdv_pkg::WAVE_TRIANGLE));
    reg_write(tocdv_pkg::REG_WAVE_C, 32'(tocdv_pkg::WAVE_SQUARE));
    reg_write(tocdv_pkg::REG_NOTE_LENGTH, 32'd0);
    queue_start(STEP_MAX, 31'h1234_5678, STEP_MAX);
    queue_samples(2);
    settle();

    reg_write(tocdv_pkg::REG_WAVE_A, 32'(tocdv_pkg::WAVE_SAW));
    reg_write(tocdv_pkg::REG_WAVE_B, 32'(tocdv_pkg::WAVE_SAW));
    reg_write(tocdv_pkg::REG_WAVE_C, 32'(tocdv_pkg::WAVE_SAW));
    reg_write(tocdv_pkg::REG_NOTE_LENGTH, 32'd65535);
    queue_start(STEP_MAX, 31'h2AAA_AAAA, 31'h0100_0000);
    queue_samples(3);
    settle();

    // shorten the note while it still runs
    reg_write(tocdv_pkg::REG_NOTE_LENGTH, 32'd2);
    queue_samples(3);
    settle();
    reg_write(tocdv_pkg::REG_NOTE_LENGTH, 32'd1);
    queue_start(31'h5555_5555, STEP_MAX, '0);
    queue_samples(2);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      reg_write(tocdv_pkg::REG_WAVE_A, $urandom_range(0, 3));
      reg_write(tocdv_pkg::REG_WAVE_B, $urandom_range(0, 3));
      reg_write(tocdv_pkg::REG_WAVE_C, $urandom_range(0, 3));
      case ($urandom_range(0, 19))
        0:       len = '0;
        1, 2:    len = '1;
        3, 4:    len = 16'($urandom);
        5, 6, 7: len = 16'($urandom_range(41, 400));
        default: len = 16'($urandom_range(1, 40));
      endcase
      reg_write(tocdv_pkg::REG_NOTE_LENGTH, {16'd0, len});
      budget = PHASE_ITEMS;
      while (budget > 0) begin
        if ($urandom_range(0, 9) != 0) begin
          n = int'(len) + $urandom_range(0, 3);
          if (n > NOTE_CAP) n = NOTE_CAP;
          if (n > budget - 1) n = budget - 1;
          queue_start(rand_step(), rand_step(), rand_step());
          queue_samples(n);
          budget -= n + 1;
        end else begin
          it.op = 1'($urandom_range(0, 1));
          it.sa = rand_step();
          it.sb = rand_step();
          it.sc = rand_step();
          pending_items.push_back(it);
          budget--;
        end
      end
      settle();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(64'd18_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
